@@ hw/rtl/pbrm_pkg.sv @@
`timescale 1ns / 1ps

package pbrm_pkg;

  localparam int BLOCK_MAX_DEF = 256;
  localparam int SHIFT_W       = 5;
  localparam logic [SHIFT_W-1:0] SHIFT_RESET = 5'd14;

  localparam logic signed [31:0] PCM_MAX_W = 32'sd32767;
  localparam logic signed [31:0] PCM_MIN_W = -32'sd32768;
  localparam logic signed [15:0] PCM_MAX   = 16'sh7fff;
  localparam logic signed [15:0] PCM_MIN   = 16'sh8000;

  // square of a 16-bit sample is at most 2^30
  localparam int SQ_W   = 31;
  // root datapath: mean fits in SQ_W bits, trial sums need one more
  localparam int ROOT_W = SQ_W + 1;

  typedef enum logic [5:0] {
    ST_IDLE = 6'b000001,
    ST_SQ   = 6'b000010,
    ST_ACC  = 6'b000100,
    ST_DIV  = 6'b001000,
    ST_SQRT = 6'b010000,
    ST_OUT  = 6'b100000
  } state_t;

endpackage

@@ hw/rtl/pcm_block_rms_meter_top.sv @@
`timescale 1ns / 1ps

// Block RMS level meter. Each input beat carries one raw 32-bit microphone
// word; it is shifted right arithmetically by the cfg shift amount, saturated
// to signed 16 bits and returned as out_pcm_sample, and its square is added
// to the block energy. A block closes on in_end_of_block or after BLOCK_MAX
// samples; that beat also carries out_level = floor(sqrt(energy / count)) and
// out_block_samples. One beat is in flight at a time. A sample that does not
// close a block passes through the square, accumulate and output states
// before the next acceptance, and the output state holds while out_stall is
// high; a closing sample also runs EW = 30 + clog2(BLOCK_MAX + 1) divide
// steps and 16 root steps, all run one bit per cycle
// through a single shared compare-and-subtract unit. Write cfg_data only
// while the block is idle.
module pcm_block_rms_meter_top
  import pbrm_pkg::*;
#(
  parameter int BLOCK_MAX = BLOCK_MAX_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic signed [31:0]  in_raw_word,
  input  logic                in_end_of_block,
  output logic                out_valid,
  input  logic                out_stall,
  output logic signed [15:0]  out_pcm_sample,
  output logic                out_level_valid,
  output logic        [15:0]  out_level,
  output logic        [8:0]   out_block_samples,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [SHIFT_W-1:0]  cfg_data
);

  localparam int CW = $clog2(BLOCK_MAX + 1);
  localparam int EW = SQ_W - 1 + CW;
  localparam int IW = $clog2(EW);
  localparam int SW = (CW + 1 > ROOT_W) ? CW + 1 : ROOT_W;
  localparam int XW = ROOT_W - 1;

  state_t               state_r, state_nxt;
  logic [SHIFT_W-1:0]   shift_r, shift_nxt;
  logic [EW-1:0]        energy_r, energy_nxt;
  logic [CW-1:0]        count_r, count_nxt;
  logic                 eob_r, eob_nxt;
  logic [SQ_W-1:0]      sq_r, sq_nxt;
  logic [EW-1:0]        q_r, q_nxt;
  logic [CW-1:0]        rem_r, rem_nxt;
  logic [CW-1:0]        dcnt_r, dcnt_nxt;
  logic [IW-1:0]        iter_r, iter_nxt;
  logic [XW-1:0]        x_r, x_nxt;
  logic [XW-1:0]        root_r, root_nxt;
  logic [XW-1:0]        bit_r, bit_nxt;
  logic signed [15:0]   pcm_r, pcm_nxt;
  logic                 lvl_valid_r, lvl_valid_nxt;
  logic [15:0]          level_r, level_nxt;
  logic [8:0]           bsamp_r, bsamp_nxt;

  logic signed [31:0]   shifted;
  logic signed [15:0]   sat_sample;
  logic signed [31:0]   product;
  logic [EW-1:0]        e_new;
  logic [CW-1:0]        c_new;
  logic                 close;
  logic [CW:0]          trial;
  logic [ROOT_W-1:0]    root_sum;
  logic [XW-1:0]        root_step;
  logic [SW-1:0]        ua, ub;
  logic [SW:0]          diff;
  logic                 ge;

  assign shifted = in_raw_word >>> shift_r;
  assign sat_sample = (shifted > PCM_MAX_W) ? PCM_MAX :
                      (shifted < PCM_MIN_W) ? PCM_MIN : shifted[15:0];

  assign product = 32'(pcm_r) * 32'(pcm_r);

  assign e_new = energy_r + EW'(sq_r);
  assign c_new = count_r + CW'(1);
  assign close = eob_r || (c_new >= CW'(BLOCK_MAX));

  assign trial     = {rem_r, q_r[EW-1]};
  assign root_sum  = {1'b0, root_r} + {1'b0, bit_r};
  assign root_step = XW'((root_r >> 1) + bit_r);

  // shared compare-and-subtract unit
  always_comb begin
    if (state_r == ST_SQRT) begin
      ua = SW'(x_r);
      ub = SW'(root_sum);
    end else begin
      ua = SW'(trial);
      ub = SW'(dcnt_r);
    end
  end

  assign diff = {1'b0, ua} - {1'b0, ub};
  assign ge   = ~diff[SW];

  always_comb begin
    state_nxt     = state_r;
    shift_nxt     = shift_r;
    energy_nxt    = energy_r;
    count_nxt     = count_r;
    eob_nxt       = eob_r;
    sq_nxt        = sq_r;
    q_nxt         = q_r;
    rem_nxt       = rem_r;
    dcnt_nxt      = dcnt_r;
    iter_nxt      = iter_r;
    x_nxt         = x_r;
    root_nxt      = root_r;
    bit_nxt       = bit_r;
    pcm_nxt       = pcm_r;
    lvl_valid_nxt = lvl_valid_r;
    level_nxt     = level_r;
    bsamp_nxt     = bsamp_r;

    if (cfg_valid) begin
      shift_nxt = cfg_data;
    end

    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          pcm_nxt   = sat_sample;
          eob_nxt   = in_end_of_block;
          state_nxt = ST_SQ;
        end
      end
      ST_SQ: begin
        sq_nxt    = product[SQ_W-1:0];
        state_nxt = ST_ACC;
      end
      ST_ACC: begin
        if (close) begin
          q_nxt         = e_new;
          rem_nxt       = '0;
          dcnt_nxt      = c_new;
          iter_nxt      = IW'(EW - 1);
          energy_nxt    = '0;
          count_nxt     = '0;
          lvl_valid_nxt = 1'b1;
          bsamp_nxt     = 9'(c_new);
          state_nxt     = ST_DIV;
        end else begin
          energy_nxt    = e_new;
          count_nxt     = c_new;
          lvl_valid_nxt = 1'b0;
          level_nxt     = '0;
          bsamp_nxt     = '0;
          state_nxt     = ST_OUT;
        end
      end
      ST_DIV: begin
        rem_nxt = ge ? diff[CW-1:0] : trial[CW-1:0];
        q_nxt   = {q_r[EW-2:0], ge};
        if (iter_r == '0) begin
          x_nxt     = q_nxt[XW-1:0];
          root_nxt  = '0;
          bit_nxt   = XW'(1) << (XW - 1);
          state_nxt = ST_SQRT;
        end else begin
          iter_nxt = iter_r - IW'(1);
        end
      end
      ST_SQRT: begin
        if (ge) begin
          x_nxt    = diff[XW-1:0];
          root_nxt = root_step;
        end else begin
          root_nxt = root_r >> 1;
        end
        bit_nxt = bit_r >> 2;
        if (bit_r[0]) begin
          level_nxt = root_nxt[15:0];
          state_nxt = ST_OUT;
        end
      end
      ST_OUT: begin
        if (!out_stall) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      shift_r  <= SHIFT_RESET;
      energy_r <= '0;
      count_r  <= '0;
    end else begin
      state_r  <= state_nxt;
      shift_r  <= shift_nxt;
      energy_r <= energy_nxt;
      count_r  <= count_nxt;
    end
    eob_r       <= eob_nxt;
    sq_r        <= sq_nxt;
    q_r         <= q_nxt;
    rem_r       <= rem_nxt;
    dcnt_r      <= dcnt_nxt;
    iter_r      <= iter_nxt;
    x_r         <= x_nxt;
    root_r      <= root_nxt;
    bit_r       <= bit_nxt;
    pcm_r       <= pcm_nxt;
    lvl_valid_r <= lvl_valid_nxt;
    level_r     <= level_nxt;
    bsamp_r     <= bsamp_nxt;
  end

  assign in_stall          = (state_r != ST_IDLE);
  assign out_valid         = (state_r == ST_OUT);
  assign out_pcm_sample    = pcm_r;
  assign out_level_valid   = lvl_valid_r;
  assign out_level         = level_r;
  assign out_block_samples = bsamp_r;
  assign cfg_ready         = 1'b1;

  a_accept_excl: assert property (@(posedge clk) disable iff (!rst_n)
    !in_stall |-> !out_valid)
    else $error("input accepted while a result beat is pending");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r < CW'(BLOCK_MAX))
    else $error("sample count reached block limit without closing");

  a_open_fields: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_level_valid) |-> (out_level == '0 && out_block_samples == '0))
    else $error("level fields set on a beat that does not close a block");

  a_level_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_level <= 16'd32768))
    else $error("level out of range");

endmodule
